// ===== sv/exptok_pkg.sv =====
// Expression tokenizer package: token and error codes, character constants,
// the result record and the operator decode functions.
// Used by every module of the tokenizer; depends on nothing.
`default_nettype none

package exptok_pkg;

  // Token kinds
  localparam logic [4:0] TK_END      = 5'd0;
  localparam logic [4:0] TK_NUMBER   = 5'd1;
  localparam logic [4:0] TK_IDENT    = 5'd2;
  localparam logic [4:0] TK_PLUS     = 5'd3;
  localparam logic [4:0] TK_MINUS    = 5'd4;
  localparam logic [4:0] TK_POW      = 5'd5;
  localparam logic [4:0] TK_STAR     = 5'd6;
  localparam logic [4:0] TK_SLASH    = 5'd7;
  localparam logic [4:0] TK_MOD      = 5'd8;
  localparam logic [4:0] TK_LPAREN   = 5'd9;
  localparam logic [4:0] TK_RPAREN   = 5'd10;
  localparam logic [4:0] TK_EQ       = 5'd11;
  localparam logic [4:0] TK_ASSIGN   = 5'd12;
  localparam logic [4:0] TK_GE       = 5'd13;
  localparam logic [4:0] TK_GT       = 5'd14;
  localparam logic [4:0] TK_LE       = 5'd15;
  localparam logic [4:0] TK_LT       = 5'd16;
  localparam logic [4:0] TK_NE       = 5'd17;
  localparam logic [4:0] TK_LOG_NOT  = 5'd18;
  localparam logic [4:0] TK_LOG_AND  = 5'd19;
  localparam logic [4:0] TK_LOG_OR   = 5'd20;
  localparam logic [4:0] TK_QUESTION = 5'd21;
  localparam logic [4:0] TK_COLON    = 5'd22;
  localparam logic [4:0] TK_COMMA    = 5'd23;
  localparam logic [4:0] TK_ERROR    = 5'd24;

  // Error codes
  localparam logic [2:0] ERR_NONE    = 3'd0;
  localparam logic [2:0] ERR_BAD_NUM = 3'd1;
  localparam logic [2:0] ERR_LONE_AMP = 3'd2;
  localparam logic [2:0] ERR_LONE_BAR = 3'd3;
  localparam logic [2:0] ERR_BAD_CHAR = 3'd4;

  // Character codes
  localparam logic [7:0] CH_TAB      = 8'h09;
  localparam logic [7:0] CH_CR       = 8'h0D;
  localparam logic [7:0] CH_SPACE    = 8'h20;
  localparam logic [7:0] CH_BANG     = 8'h21;
  localparam logic [7:0] CH_PERCENT  = 8'h25;
  localparam logic [7:0] CH_AMP      = 8'h26;
  localparam logic [7:0] CH_LPAREN   = 8'h28;
  localparam logic [7:0] CH_RPAREN   = 8'h29;
  localparam logic [7:0] CH_STAR     = 8'h2A;
  localparam logic [7:0] CH_PLUS     = 8'h2B;
  localparam logic [7:0] CH_COMMA    = 8'h2C;
  localparam logic [7:0] CH_MINUS    = 8'h2D;
  localparam logic [7:0] CH_DOT      = 8'h2E;
  localparam logic [7:0] CH_SLASH    = 8'h2F;
  localparam logic [7:0] CH_ZERO     = 8'h30;
  localparam logic [7:0] CH_NINE     = 8'h39;
  localparam logic [7:0] CH_COLON    = 8'h3A;
  localparam logic [7:0] CH_LT       = 8'h3C;
  localparam logic [7:0] CH_EQUAL    = 8'h3D;
  localparam logic [7:0] CH_GT       = 8'h3E;
  localparam logic [7:0] CH_QUESTION = 8'h3F;
  localparam logic [7:0] CH_UPPER_A  = 8'h41;
  localparam logic [7:0] CH_UPPER_Z  = 8'h5A;
  localparam logic [7:0] CH_CARET    = 8'h5E;
  localparam logic [7:0] CH_UNDER    = 8'h5F;
  localparam logic [7:0] CH_LOWER_A  = 8'h61;
  localparam logic [7:0] CH_LOWER_Z  = 8'h7A;
  localparam logic [7:0] CH_BAR      = 8'h7C;

  // Result queue geometry
  localparam int unsigned RQ_DEPTH    = 4;
  localparam int unsigned RQ_PTR_BITS = 2;
  localparam int unsigned RQ_CNT_BITS = 3;

  // One result item
  typedef struct packed {
    logic [4:0]  kind;
    logic [2:0]  err;
    logic [7:0]  bad;
    logic [15:0] start;
    logic [15:0] len;
    logic [47:0] mant;
    logic [7:0]  frac;
    logic        sat;
    logic        last;
  } result_t;

  // Decode of a single-character operator
  typedef struct packed {
    logic [4:0] kind;
    logic [2:0] err;
    logic [7:0] bad;
  } op_t;

  function automatic op_t single_op(input logic [7:0] c);
    op_t r;
    r.kind = TK_ERROR;
    r.err  = ERR_NONE;
    r.bad  = 8'd0;
    case (c)
      CH_PLUS:     r.kind = TK_PLUS;
      CH_MINUS:    r.kind = TK_MINUS;
      CH_CARET:    r.kind = TK_POW;
      CH_STAR:     r.kind = TK_STAR;
      CH_SLASH:    r.kind = TK_SLASH;
      CH_PERCENT:  r.kind = TK_MOD;
      CH_LPAREN:   r.kind = TK_LPAREN;
      CH_RPAREN:   r.kind = TK_RPAREN;
      CH_EQUAL:    r.kind = TK_ASSIGN;
      CH_GT:       r.kind = TK_GT;
      CH_LT:       r.kind = TK_LT;
      CH_BANG:     r.kind = TK_LOG_NOT;
      CH_AMP:      r.err  = ERR_LONE_AMP;
      CH_BAR:      r.err  = ERR_LONE_BAR;
      CH_QUESTION: r.kind = TK_QUESTION;
      CH_COLON:    r.kind = TK_COLON;
      CH_COMMA:    r.kind = TK_COMMA;
      default: begin
        r.err = ERR_BAD_CHAR;
        r.bad = c;
      end
    endcase
    return r;
  endfunction

  // Two-character operator for pending p then c; TK_END when no pair matches
  function automatic logic [4:0] pair_op(input logic [7:0] p, input logic [7:0] c);
    logic [4:0] k;
    k = TK_END;
    if (p == CH_STAR && c == CH_STAR) begin
      k = TK_POW;
    end else if (c == CH_EQUAL && p == CH_EQUAL) begin
      k = TK_EQ;
    end else if (c == CH_EQUAL && p == CH_GT) begin
      k = TK_GE;
    end else if (c == CH_EQUAL && p == CH_LT) begin
      k = TK_LE;
    end else if (c == CH_EQUAL && p == CH_BANG) begin
      k = TK_NE;
    end else if (p == CH_AMP && c == CH_AMP) begin
      k = TK_LOG_AND;
    end else if (p == CH_BAR && c == CH_BAR) begin
      k = TK_LOG_OR;
    end
    return k;
  endfunction

endpackage

`default_nettype wire

// ===== sv/expression_tokenizer.sv =====
// Expression tokenizer, top level: input register, scanner and result queue.
// Depends on exptok_pkg, exptok_scan and exptok_fifo.
//
// Takes one source character (or an end-of-source marker) per item and gives
// tokens: numbers as decimal mantissa plus fraction-digit count, identifiers
// as offset and length, operators, errors and END. An item is taken in every
// cycle unless input stalls; it is held in the input register and scanned
// from there in one pass. Its results are then written to the queue, whose
// head drives the output straight from the queue registers. Most items give
// zero or one result; one that closes a pending token and also makes a token
// of its own gives two, which leave at one per cycle while the output is not
// stalled. Results wait in a four-entry queue, and input stalls while that
// queue holds more than two, so a run of two-result items is paced by the
// single output port.
`default_nettype none

module expression_tokenizer #(
  parameter int unsigned POSITION_BITS = 16,
  parameter int unsigned MANTISSA_BITS = 48
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        kind_i,
  input  logic [7:0]  char_code_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [4:0]  token_kind_o,
  output logic [2:0]  error_code_o,
  output logic [7:0]  bad_char_o,
  output logic [15:0] start_offset_o,
  output logic [15:0] token_length_o,
  output logic [47:0] mantissa_o,
  output logic [7:0]  frac_digits_o,
  output logic        mantissa_saturated_o,
  output logic        last_o
);
  import exptok_pkg::*;

  logic       in_vld_q;
  logic       kind_q;
  logic [7:0] char_q;
  logic       room, go, pop;
  result_t    res0, res1, head;
  logic       vld0, vld1;

  // input register: loads whenever it is not held by a queue that lacks room for two results
  assign go         = in_vld_q && room;
  assign in_stall_o = in_vld_q && !room;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      kind_q <= kind_i;
      char_q <= char_code_i;
    end
  end

  exptok_scan #(
    .POSITION_BITS (POSITION_BITS),
    .MANTISSA_BITS (MANTISSA_BITS)
  ) u_scan (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .go_i   (go),
    .kind_i (kind_q),
    .char_i (char_q),
    .res0_o (res0),
    .res1_o (res1),
    .vld0_o (vld0),
    .vld1_o (vld1)
  );

  exptok_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push0_i    (vld0),
    .push1_i    (vld1),
    .data0_i    (res0),
    .data1_i    (res1),
    .pop_i      (pop),
    .head_o     (head),
    .nonempty_o (out_valid_o),
    .room_o     (room)
  );

  assign pop = out_valid_o && !out_stall_i;

  // result item fields
  assign token_kind_o         = head.kind;
  assign error_code_o         = head.err;
  assign bad_char_o           = head.bad;
  assign start_offset_o       = head.start;
  assign token_length_o       = head.len;
  assign mantissa_o           = head.mant;
  assign frac_digits_o        = head.frac;
  assign mantissa_saturated_o = head.sat;
  assign last_o               = head.last;

endmodule

`default_nettype wire

// ===== sv/exptok_fifo.sv =====
// Result queue of the expression tokenizer: four entries, up to two pushes
// and one pop per cycle, head shown straight from the register array.
// Depends on exptok_pkg.
`default_nettype none

module exptok_fifo (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push0_i,
  input  logic                 push1_i,
  input  exptok_pkg::result_t  data0_i,
  input  exptok_pkg::result_t  data1_i,
  input  logic                 pop_i,
  output exptok_pkg::result_t  head_o,
  output logic                 nonempty_o,
  output logic                 room_o
);
  import exptok_pkg::*;

  result_t                mem_q [RQ_DEPTH];
  logic [RQ_PTR_BITS-1:0] wr_q, wr_d;
  logic [RQ_PTR_BITS-1:0] rd_q, rd_d;
  logic [RQ_CNT_BITS-1:0] cnt_q, cnt_d;
  logic [RQ_PTR_BITS-1:0] wr_next;

  // pointer and fill arithmetic
  always_comb begin
    wr_next = wr_q + RQ_PTR_BITS'(1);
    wr_d    = wr_q + RQ_PTR_BITS'(push0_i) + RQ_PTR_BITS'(push1_i);
    rd_d    = rd_q + RQ_PTR_BITS'(pop_i);
    cnt_d   = cnt_q + RQ_CNT_BITS'(push0_i) + RQ_CNT_BITS'(push1_i)
              - RQ_CNT_BITS'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // storage: second push lands one slot after the first
  always_ff @(posedge clk_i) begin
    if (push0_i) begin
      mem_q[wr_q] <= data0_i;
    end
    if (push1_i) begin
      mem_q[wr_next] <= data1_i;
    end
  end

  assign head_o     = mem_q[rd_q];
  assign nonempty_o = (cnt_q != '0);
  // room for the worst case of two results from one item
  assign room_o     = (cnt_q <= RQ_CNT_BITS'(RQ_DEPTH - 2));

endmodule

`default_nettype wire

// ===== sv/exptok_scan.sv =====
// Scanner of the expression tokenizer: holds the scan state and turns one
// character or end item into at most two result items in a single pass.
// Depends on exptok_pkg.
`default_nettype none

module exptok_scan #(
  parameter int unsigned POSITION_BITS = 16,
  parameter int unsigned MANTISSA_BITS = 48
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 go_i,
  input  logic                 kind_i,
  input  logic [7:0]           char_i,
  output exptok_pkg::result_t  res0_o,
  output exptok_pkg::result_t  res1_o,
  output logic                 vld0_o,
  output logic                 vld1_o
);
  import exptok_pkg::*;

  localparam logic [1:0] MODE_IDLE  = 2'd0;
  localparam logic [1:0] MODE_NUM   = 2'd1;
  localparam logic [1:0] MODE_IDENT = 2'd2;
  localparam logic [1:0] MODE_OP    = 2'd3;

  localparam int unsigned PB = POSITION_BITS;
  localparam int unsigned MB = MANTISSA_BITS;

  // scan state
  logic [1:0]    mode_q, mode_d;
  logic [7:0]    pend_q, pend_d;
  logic          dot_q, dot_d;
  logic          dig_q, dig_d;
  logic [PB-1:0] pos_q, pos_d;
  logic [PB-1:0] start_q, start_d;
  logic [MB-1:0] acc_q, acc_d;
  logic [7:0]    frac_q, frac_d;
  logic          ovf_q, ovf_d;
  logic [15:0]   len_q, len_d;

  // character classes
  logic       is_digit, is_alpha, is_space, is_word, is_opstart;
  logic [3:0] dig_val;

  logic [MB+3:0] acc_x10;
  logic          acc_ovf;
  logic [MB-1:0] acc_add;
  logic          frac_full;
  logic [15:0]   len_inc;
  logic [4:0]    pair_k;
  op_t           pend_op, char_op;
  result_t       flush_res, char_res;
  logic          flush_vld, char_vld, use_flush, cont;

  always_comb begin
    is_digit   = char_i inside {[CH_ZERO:CH_NINE]};
    is_alpha   = char_i inside {[CH_LOWER_A:CH_LOWER_Z], [CH_UPPER_A:CH_UPPER_Z]};
    is_space   = char_i inside {CH_SPACE, [CH_TAB:CH_CR]};
    is_word    = is_alpha || is_digit || (char_i == CH_UNDER);
    is_opstart = char_i inside {CH_STAR, CH_EQUAL, CH_GT, CH_LT, CH_BANG, CH_AMP,
                                CH_BAR};
    dig_val    = char_i[3:0];
  end

  // mantissa times ten plus digit; any carry above MB bits is saturation
  always_comb begin
    acc_x10   = ({4'd0, acc_q} << 3) + ({4'd0, acc_q} << 1) + (MB + 4)'(dig_val);
    acc_ovf   = |acc_x10[MB+3:MB];
    acc_add   = acc_ovf ? {MB{1'b1}} : acc_x10[MB-1:0];
    frac_full = (frac_q == 8'hFF);
    len_inc   = (len_q == 16'hFFFF) ? len_q : len_q + 16'd1;
    pair_k    = pair_op(pend_q, char_i);
    pend_op   = single_op(pend_q);
    char_op   = single_op(char_i);
  end

  // result for the token that is pending when the scan state is left
  always_comb begin
    flush_res       = '0;
    flush_res.start = 16'(start_q);
    flush_vld       = (mode_q != MODE_IDLE);
    case (mode_q)
      MODE_NUM: begin
        flush_res.len = len_q;
        if (dig_q) begin
          flush_res.kind = TK_NUMBER;
          flush_res.mant = 48'(acc_q);
          flush_res.frac = frac_q;
          flush_res.sat  = ovf_q;
        end else begin
          flush_res.kind = TK_ERROR;
          flush_res.err  = ERR_BAD_NUM;
        end
      end
      MODE_IDENT: begin
        flush_res.kind = TK_IDENT;
        flush_res.len  = len_q;
      end
      MODE_OP: begin
        flush_res.kind = pend_op.kind;
        flush_res.err  = pend_op.err;
        flush_res.bad  = pend_op.bad;
        flush_res.len  = 16'd1;
      end
      default: begin
      end
    endcase
  end

  // next scan state and the item's own result
  always_comb begin
    mode_d    = mode_q;
    pend_d    = pend_q;
    dot_d     = dot_q;
    dig_d     = dig_q;
    pos_d     = pos_q + PB'(1);
    start_d   = start_q;
    acc_d     = acc_q;
    frac_d    = frac_q;
    ovf_d     = ovf_q;
    len_d     = len_q;
    char_res  = '0;
    char_vld  = 1'b0;
    use_flush = 1'b0;
    cont      = 1'b0;

    if (kind_i) begin
      // end of source: flush, END, back to the reset state
      use_flush      = flush_vld;
      char_res.kind  = TK_END;
      char_res.start = 16'(pos_q);
      char_vld       = 1'b1;
      mode_d         = MODE_IDLE;
      pend_d         = 8'd0;
      dot_d          = 1'b0;
      dig_d          = 1'b0;
      pos_d          = '0;
      start_d        = '0;
      acc_d          = '0;
      frac_d         = 8'd0;
      ovf_d          = 1'b0;
      len_d          = 16'd0;
    end else begin
      // continue the pending token where the character fits it
      case (mode_q)
        MODE_NUM: begin
          if (is_digit) begin
            cont  = 1'b1;
            acc_d = acc_add;
            ovf_d = ovf_q || acc_ovf || (dot_q && frac_full);
            if (dot_q && !frac_full) begin
              frac_d = frac_q + 8'd1;
            end
            dig_d = 1'b1;
            len_d = len_inc;
          end else if (char_i == CH_DOT && !dot_q) begin
            cont  = 1'b1;
            dot_d = 1'b1;
            len_d = len_inc;
          end
        end
        MODE_IDENT: begin
          if (is_word) begin
            cont  = 1'b1;
            len_d = len_inc;
          end
        end
        MODE_OP: begin
          if (pair_k != TK_END) begin
            cont           = 1'b1;
            char_res.kind  = pair_k;
            char_res.start = 16'(start_q);
            char_res.len   = 16'd2;
            char_vld       = 1'b1;
            mode_d         = MODE_IDLE;
          end
        end
        default: begin
        end
      endcase

      // otherwise close the pending token and classify the character afresh
      if (!cont) begin
        use_flush = flush_vld;
        mode_d    = MODE_IDLE;
        if (is_space) begin
          mode_d = MODE_IDLE;
        end else if (is_digit || char_i == CH_DOT || is_alpha ||
                     char_i == CH_UNDER || is_opstart) begin
          start_d = pos_q;
          len_d   = 16'd1;
          dot_d   = 1'b0;
          dig_d   = 1'b0;
          acc_d   = '0;
          frac_d  = 8'd0;
          ovf_d   = 1'b0;
          if (is_digit) begin
            mode_d = MODE_NUM;
            dig_d  = 1'b1;
            acc_d  = MB'(dig_val);
          end else if (char_i == CH_DOT) begin
            mode_d = MODE_NUM;
            dot_d  = 1'b1;
          end else if (is_opstart) begin
            mode_d = MODE_OP;
            pend_d = char_i;
          end else begin
            mode_d = MODE_IDENT;
          end
        end else begin
          char_res.kind  = char_op.kind;
          char_res.err   = char_op.err;
          char_res.bad   = char_op.bad;
          char_res.start = 16'(pos_q);
          char_res.len   = 16'd1;
          char_vld       = 1'b1;
        end
      end
    end
  end

  // order the results; the final one carries last
  always_comb begin
    res0_o      = use_flush ? flush_res : char_res;
    res0_o.last = !(use_flush && char_vld);
    res1_o      = char_res;
    res1_o.last = 1'b1;
    vld0_o      = go_i && (use_flush || char_vld);
    vld1_o      = go_i && use_flush && char_vld;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_IDLE;
      pend_q  <= 8'd0;
      dot_q   <= 1'b0;
      dig_q   <= 1'b0;
      pos_q   <= '0;
      start_q <= '0;
      acc_q   <= '0;
      frac_q  <= 8'd0;
      ovf_q   <= 1'b0;
      len_q   <= 16'd0;
    end else if (go_i) begin
      mode_q  <= mode_d;
      pend_q  <= pend_d;
      dot_q   <= dot_d;
      dig_q   <= dig_d;
      pos_q   <= pos_d;
      start_q <= start_d;
      acc_q   <= acc_d;
      frac_q  <= frac_d;
      ovf_q   <= ovf_d;
      len_q   <= len_d;
    end
  end

endmodule

`default_nettype wire

// ===== tb/sv/tb_expression_tokenizer.sv =====
// Testbench for expression_tokenizer: random and directed character streams,
// with a scoreboard that predicts every token and checks each output item.
// Depends on exptok_pkg and the expression_tokenizer RTL.
module tb_expression_tokenizer;
  timeunit 1ns;
  timeprecision 1ps;

  import exptok_pkg::*;

  typedef enum logic [1:0] {SCAN_IDLE, SCAN_NUM, SCAN_IDENT, SCAN_OP} scan_mode_e;

  // Token predictor and store of expected tokens
  class token_scoreboard;
    result_t     pending_tokens[$];
    int unsigned mismatches;
    logic [4:0]  single_kind[256];
    scan_mode_e  mode;
    logic [7:0]  held_op;
    bit          dot_seen;
    bit          digit_seen;
    bit          mant_sat;
    logic [15:0] position;
    logic [15:0] tok_start;
    logic [15:0] tok_len;
    logic [47:0] mant_acc;
    logic [7:0]  frac_cnt;
    result_t     staged;
    bit          staged_valid;

    function new();
      foreach (single_kind[i]) single_kind[i] = TK_ERROR;
      single_kind[CH_PLUS]     = TK_PLUS;
      single_kind[CH_MINUS]    = TK_MINUS;
      single_kind[CH_CARET]    = TK_POW;
      single_kind[CH_STAR]     = TK_STAR;
      single_kind[CH_SLASH]    = TK_SLASH;
      single_kind[CH_PERCENT]  = TK_MOD;
      single_kind[CH_LPAREN]   = TK_LPAREN;
      single_kind[CH_RPAREN]   = TK_RPAREN;
      single_kind[CH_EQUAL]    = TK_ASSIGN;
      single_kind[CH_GT]       = TK_GT;
      single_kind[CH_LT]       = TK_LT;
      single_kind[CH_BANG]     = TK_LOG_NOT;
      single_kind[CH_QUESTION] = TK_QUESTION;
      single_kind[CH_COLON]    = TK_COLON;
      single_kind[CH_COMMA]    = TK_COMMA;
      mismatches   = 0;
      staged_valid = 1'b0;
      restart();
    endfunction

    function void restart();
      mode       = SCAN_IDLE;
      held_op    = 8'd0;
      dot_seen   = 1'b0;
      digit_seen = 1'b0;
      mant_sat   = 1'b0;
      position   = 16'd0;
      tok_start  = 16'd0;
      tok_len    = 16'd0;
      mant_acc   = 48'd0;
      frac_cnt   = 8'd0;
    endfunction

    function bit is_digit(logic [7:0] c);
      return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    function bit is_alpha(logic [7:0] c);
      return (c >= CH_LOWER_A && c <= CH_LOWER_Z) || (c >= CH_UPPER_A && c <= CH_UPPER_Z);
    endfunction

    function bit is_blank(logic [7:0] c);
      return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function bit starts_pair(logic [7:0] c);
      return c == CH_STAR || c == CH_EQUAL || c == CH_GT || c == CH_LT ||
             c == CH_BANG || c == CH_AMP || c == CH_BAR;
    endfunction

    function void decode_single(input logic [7:0] c, output logic [4:0] k,
                                output logic [2:0] e, output logic [7:0] b);
      k = single_kind[c];
      b = 8'd0;
      if (k != TK_ERROR) e = ERR_NONE;
      else if (c == CH_AMP) e = ERR_LONE_AMP;
      else if (c == CH_BAR) e = ERR_LONE_BAR;
      else begin
        e = ERR_BAD_CHAR;
        b = c;
      end
    endfunction

    // TK_END means the two characters do not form an operator
    function logic [4:0] decode_pair(logic [7:0] p, logic [7:0] c);
      case ({p, c})
        {CH_STAR, CH_STAR}:   return TK_POW;
        {CH_EQUAL, CH_EQUAL}: return TK_EQ;
        {CH_GT, CH_EQUAL}:    return TK_GE;
        {CH_LT, CH_EQUAL}:    return TK_LE;
        {CH_BANG, CH_EQUAL}:  return TK_NE;
        {CH_AMP, CH_AMP}:     return TK_LOG_AND;
        {CH_BAR, CH_BAR}:     return TK_LOG_OR;
        default:              return TK_END;
      endcase
    endfunction

    // the previous token goes to the store once a newer one exists
    function void stage_token(logic [4:0] k, logic [2:0] e, logic [7:0] b,
                              logic [15:0] s, logic [15:0] l, logic [47:0] m,
                              logic [7:0] f, bit sat);
      if (staged_valid) pending_tokens.push_back(staged);
      staged.kind  = k;
      staged.err   = e;
      staged.bad   = b;
      staged.start = s;
      staged.len   = l;
      staged.mant  = m;
      staged.frac  = f;
      staged.sat   = sat;
      staged.last  = 1'b0;
      staged_valid = 1'b1;
    endfunction

    function void bump_len();
      if (tok_len != 16'hFFFF) tok_len = tok_len + 16'd1;
    endfunction

    function void open_token(scan_mode_e m);
      mode       = m;
      tok_start  = position;
      tok_len    = 16'd1;
      dot_seen   = 1'b0;
      digit_seen = 1'b0;
      mant_acc   = 48'd0;
      frac_cnt   = 8'd0;
      mant_sat   = 1'b0;
    endfunction

    // mantissa holds at all ones; fraction count holds at 255
    function void take_digit(logic [7:0] c);
      logic [63:0] d;
      logic [63:0] wide;
      d = 64'(c - CH_ZERO);
      if ({16'd0, mant_acc} > (64'hFFFF_FFFF_FFFF - d) / 64'd10) begin
        mant_acc = '1;
        mant_sat = 1'b1;
      end else begin
        wide     = {16'd0, mant_acc} * 64'd10 + d;
        mant_acc = wide[47:0];
      end
      if (dot_seen) begin
        if (frac_cnt != 8'hFF) frac_cnt = frac_cnt + 8'd1;
        else mant_sat = 1'b1;
      end
      digit_seen = 1'b1;
    endfunction

    function void close_token();
      logic [4:0] k;
      logic [2:0] e;
      logic [7:0] b;
      case (mode)
        SCAN_NUM: begin
          if (digit_seen)
            stage_token(TK_NUMBER, ERR_NONE, 8'd0, tok_start, tok_len, mant_acc,
                        frac_cnt, mant_sat);
          else
            stage_token(TK_ERROR, ERR_BAD_NUM, 8'd0, tok_start, tok_len, 48'd0, 8'd0, 1'b0);
        end
        SCAN_IDENT: begin
          stage_token(TK_IDENT, ERR_NONE, 8'd0, tok_start, tok_len, 48'd0, 8'd0, 1'b0);
        end
        SCAN_OP: begin
          decode_single(held_op, k, e, b);
          stage_token(k, e, b, tok_start, 16'd1, 48'd0, 8'd0, 1'b0);
        end
        default: ;
      endcase
      mode = SCAN_IDLE;
    endfunction

    // Predict the tokens caused by one accepted input item
    function void expect_tokens(bit is_end, logic [7:0] c);
      logic [4:0] k;
      logic [2:0] e;
      logic [7:0] b;
      bit         taken;
      taken = 1'b0;
      if (is_end) begin
        close_token();
        stage_token(TK_END, ERR_NONE, 8'd0, position, 16'd0, 48'd0, 8'd0, 1'b0);
        restart();
      end else begin
        // extend or close the token in progress
        case (mode)
          SCAN_NUM: begin
            if (is_digit(c)) begin
              take_digit(c);
              bump_len();
              taken = 1'b1;
            end else if (c == CH_DOT && !dot_seen) begin
              dot_seen = 1'b1;
              bump_len();
              taken = 1'b1;
            end else close_token();
          end
          SCAN_IDENT: begin
            if (is_alpha(c) || is_digit(c) || c == CH_UNDER) begin
              bump_len();
              taken = 1'b1;
            end else close_token();
          end
          SCAN_OP: begin
            k = decode_pair(held_op, c);
            if (k != TK_END) begin
              stage_token(k, ERR_NONE, 8'd0, tok_start, 16'd2, 48'd0, 8'd0, 1'b0);
              mode  = SCAN_IDLE;
              taken = 1'b1;
            end else close_token();
          end
          default: ;
        endcase
        // the character begins something of its own
        if (!taken) begin
          if (is_blank(c)) begin
          end else if (is_digit(c)) begin
            open_token(SCAN_NUM);
            take_digit(c);
          end else if (c == CH_DOT) begin
            open_token(SCAN_NUM);
            dot_seen = 1'b1;
          end else if (is_alpha(c) || c == CH_UNDER) begin
            open_token(SCAN_IDENT);
          end else if (starts_pair(c)) begin
            open_token(SCAN_OP);
            held_op = c;
          end else begin
            decode_single(c, k, e, b);
            stage_token(k, e, b, position, 16'd1, 48'd0, 8'd0, 1'b0);
          end
        end
        position = position + 16'd1;
      end
      if (staged_valid) begin
        staged.last = 1'b1;
        pending_tokens.push_back(staged);
        staged_valid = 1'b0;
      end
    endfunction

    task report_mismatch(string what, logic [63:0] got_v, logic [63:0] want_v);
      if (mismatches < 100)
        $display("%0t tokenizer mismatch: %s got 0x%0h expected 0x%0h",
                 $realtime, what, got_v, want_v);
      mismatches++;
    endtask

    task compare_field(string what, logic [63:0] got_v, logic [63:0] want_v);
      if (got_v !== want_v) report_mismatch(what, got_v, want_v);
    endtask

    task check_token(result_t got);
      result_t want;
      if (pending_tokens.size() == 0) begin
        report_mismatch("token_kind with nothing expected", 64'(got.kind), 64'd0);
      end else begin
        want = pending_tokens.pop_front();
        compare_field("token_kind", 64'(got.kind), 64'(want.kind));
        compare_field("error_code", 64'(got.err), 64'(want.err));
        compare_field("bad_char", 64'(got.bad), 64'(want.bad));
        compare_field("start_offset", 64'(got.start), 64'(want.start));
        compare_field("token_length", 64'(got.len), 64'(want.len));
        compare_field("mantissa", 64'(got.mant), 64'(want.mant));
        compare_field("frac_digits", 64'(got.frac), 64'(want.frac));
        compare_field("mantissa_saturated", 64'(got.sat), 64'(want.sat));
        compare_field("last", 64'(got.last), 64'(want.last));
      end
    endtask
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic        kind_i;
  logic [7:0]  char_code_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [4:0]  token_kind_o;
  logic [2:0]  error_code_o;
  logic [7:0]  bad_char_o;
  logic [15:0] start_offset_o;
  logic [15:0] token_length_o;
  logic [47:0] mantissa_o;
  logic [7:0]  frac_digits_o;
  logic        mantissa_saturated_o;
  logic        last_o;

  token_scoreboard sb;
  bit              idle_on = 1'b1;
  int unsigned     items_sent;

  string op_spellings [25] = '{"+", "-", "^", "*", "/", "%", "(", ")", "=", ">", "<", "!",
                               "?", ":", ",", "**", "==", ">=", "<=", "!=", "&&", "||",
                               "&", "|", "*"};

  expression_tokenizer dut (.*);

  always #6 clk_i = ~clk_i;

  // Receiver: random stalls while idling is enabled
  always @(posedge clk_i) begin
    out_stall_i <= idle_on && ($urandom_range(99) < 21);
  end

  // Accepted items on both sides go to the scoreboard
  always @(posedge clk_i) begin : monitor
    result_t seen;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        seen.kind  = token_kind_o;
        seen.err   = error_code_o;
        seen.bad   = bad_char_o;
        seen.start = start_offset_o;
        seen.len   = token_length_o;
        seen.mant  = mantissa_o;
        seen.frac  = frac_digits_o;
        seen.sat   = mantissa_saturated_o;
        seen.last  = last_o;
        sb.check_token(seen);
      end
      if (in_valid_i && !in_stall_o) sb.expect_tokens(kind_i, char_code_i);
    end
  end

  // Present one item and hold it until accepted
  task automatic drive_item(input bit is_end, input logic [7:0] c);
    while (idle_on && $urandom_range(99) < 21) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    kind_i      <= is_end;
    char_code_i <= c;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    items_sent++;
  endtask

  task automatic send_end();
    drive_item(1'b1, 8'($urandom_range(255)));
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) drive_item(1'b0, s[i]);
  endtask

  function automatic logic [7:0] ident_char(bit first);
    int r;
    r = first ? $urandom_range(52) : $urandom_range(62);
    if (r < 26) return CH_LOWER_A + 8'(r);
    else if (r < 52) return CH_UPPER_A + 8'(r - 26);
    else if (r == 52) return CH_UNDER;
    else return CH_ZERO + 8'(r - 53);
  endfunction

  function automatic logic [7:0] any_digit();
    return CH_ZERO + 8'($urandom_range(9));
  endfunction

  // Digits with at most one dot somewhere, now and then a trailing dot
  task automatic send_random_number();
    int n_digits;
    int dot_at;
    n_digits = ($urandom_range(19) == 0) ? $urandom_range(14, 20) : $urandom_range(1, 6);
    dot_at   = $urandom_range(n_digits + 3);
    for (int i = 0; i <= n_digits; i++) begin
      if (i == dot_at) drive_item(1'b0, CH_DOT);
      if (i < n_digits) drive_item(1'b0, any_digit());
    end
    if ($urandom_range(9) == 0) drive_item(1'b0, CH_DOT);
  endtask

  task automatic send_random_token();
    int pick;
    int n;
    pick = $urandom_range(99);
    if (pick < 30) begin
      send_random_number();
    end else if (pick < 55) begin
      n = $urandom_range(7);
      drive_item(1'b0, ident_char(1'b1));
      repeat (n) drive_item(1'b0, ident_char(1'b0));
    end else if (pick < 80) begin
      send_text(op_spellings[$urandom_range(24)]);
    end else if (pick < 92) begin
      n = $urandom_range(5);
      drive_item(1'b0, (n == 5) ? CH_SPACE : CH_TAB + 8'(n));
    end else begin
      drive_item(1'b0, 8'($urandom_range(255)));
    end
  endtask

  initial begin
    sb          = new();
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    kind_i      = 1'b0;
    char_code_i = 8'd0;
    out_stall_i = 1'b0;
    items_sent  = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: every operator, pending operators closed by other characters,
    // lone ampersand and bar, lone dot, dot runs, whitespace and odd codes
    send_end();
    send_text("+-^/%()?:,");
    send_text("**==>=<=!=&&||");
    send_text("*a=b>c<d!e&|x");
    send_text(". 1.2.3 _a9Z.5");
    for (int c = 9; c <= 13; c++) drive_item(1'b0, 8'(c));
    drive_item(1'b0, 8'd0);
    drive_item(1'b0, 8'd127);
    drive_item(1'b0, 8'd128);
    drive_item(1'b0, 8'd255);
    drive_item(1'b0, CH_AMP);
    send_end();
    drive_item(1'b0, CH_BAR);
    send_end();

    // Mantissa right at its maximum, one past it, and a flush by the end item
    send_text("281474976710655 281474976710656 4");
    send_end();

    // Fraction count past 255
    send_text("0.");
    repeat (270) drive_item(1'b0, any_digit());
    send_end();

    // A long identifier followed by an operator and a number
    drive_item(1'b0, ident_char(1'b1));
    repeat (40) drive_item(1'b0, ident_char(1'b0));
    send_text(" +7");
    send_end();

    // Random token streams, with a stretch free of idling on both sides
    while (items_sent < 1650) begin
      idle_on = !(items_sent >= 700 && items_sent < 1000);
      if ($urandom_range(29) == 0) send_end();
      else send_random_token();
    end
    idle_on = 1'b1;
    send_end();
    in_valid_i <= 1'b0;

    // Drain, then watch a while longer for stray results
    @(posedge clk_i);
    while (sb.pending_tokens.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
    if (sb.mismatches == 0) begin
      $display("expression_tokenizer regression: pass");
    end else begin
      $display("expression_tokenizer regression: fail");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #10_000_000;
    $display("expression_tokenizer regression: fail");
    $finish;
  end

endmodule
